// ===== hw/rtl/fbsl_pkg.sv =====
// Shared types and constants for the framed bit-serial link core.
// No dependencies; every other file of the block refers to this package.
package fbsl_pkg;

  typedef enum logic [1:0] {
    KIND_SEND   = 2'd0,
    KIND_TICK   = 2'd1,
    KIND_SAMPLE = 2'd2,
    KIND_READ   = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    PH_HUNT    = 3'b001,
    PH_COLLECT = 3'b010,
    PH_READY   = 3'b100
  } rx_phase_t;

  localparam logic [1:0] CFG_RUN_LENGTH   = 2'd0;
  localparam logic [1:0] CFG_SYNC_PATTERN = 2'd1;
  localparam logic [1:0] CFG_END_PATTERN  = 2'd2;

  localparam logic [3:0] RUN_RESET  = 4'd9;
  localparam logic [7:0] SYNC_RESET = 8'hAA;
  localparam logic [7:0] END_RESET  = 8'hCC;

  localparam logic [2:0] LAST_BIT  = 3'd7;
  localparam logic [1:0] LAST_BYTE = 2'd2;
  localparam logic [3:0] RUN_MAX   = 4'd15;

  typedef struct packed {
    logic load;
    logic tick;
    logic [7:0] data_byte;
  } tx_ctrl_t;

  typedef struct packed {
    logic busy;
    logic level_nxt;
  } tx_stat_t;

  typedef struct packed {
    logic sample;
    logic level;
    logic read;
  } rx_ctrl_t;

  typedef struct packed {
    logic ready;
    logic [7:0] shift;
  } rx_stat_t;

endpackage

// ===== hw/rtl/fbsl_if.sv =====
// Valid/ready channel interfaces for the input items and result items.
// Depends on fbsl_pkg for the item kind type.
interface fbsl_in_if;
  logic valid;
  logic ready;
  fbsl_pkg::kind_t kind;
  logic [7:0] data_byte;
  logic line_level;

  modport source (output valid, kind, data_byte, line_level, input ready);
  modport sink (input valid, kind, data_byte, line_level, output ready);
endinterface

interface fbsl_out_if;
  logic valid;
  logic ready;
  logic status;
  logic tx_line;
  logic [7:0] rx_byte;

  modport source (output valid, status, tx_line, rx_byte, input ready);
  modport sink (input valid, status, tx_line, rx_byte, output ready);
endinterface

// ===== hw/rtl/fbsl_tx.sv =====
// Transmitter: three-byte frame shift register, bit and byte counters, line level.
// Depends on fbsl_pkg for the control and status structs.
module fbsl_tx (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          sync_pattern,
  input  logic [7:0]          end_pattern,
  input  fbsl_pkg::tx_ctrl_t  ctrl,
  output fbsl_pkg::tx_stat_t  stat
);

  logic [23:0] frame_r, frame_nxt;
  logic [2:0]  bit_r, bit_nxt;
  logic [1:0]  byte_r, byte_nxt;
  logic        busy_r, busy_nxt;
  logic        level_r, level_nxt;

  always_comb begin
    frame_nxt = frame_r;
    bit_nxt   = bit_r;
    byte_nxt  = byte_r;
    busy_nxt  = busy_r;
    level_nxt = level_r;
    if (ctrl.load && !busy_r) begin
      frame_nxt = {sync_pattern, ctrl.data_byte, end_pattern};
      bit_nxt   = '0;
      byte_nxt  = '0;
      busy_nxt  = 1'b1;
    end else if (ctrl.tick && busy_r) begin
      level_nxt = frame_r[23];
      frame_nxt = {frame_r[22:0], 1'b0};
      bit_nxt   = bit_r + 3'd1;
      if (bit_r == fbsl_pkg::LAST_BIT) begin
        byte_nxt = byte_r + 2'd1;
        if (byte_r == fbsl_pkg::LAST_BYTE) begin
          byte_nxt = '0;
          busy_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    frame_r <= frame_nxt;
    if (!rst_n) begin
      bit_r   <= '0;
      byte_r  <= '0;
      busy_r  <= 1'b0;
      level_r <= 1'b0;
    end else begin
      bit_r   <= bit_nxt;
      byte_r  <= byte_nxt;
      busy_r  <= busy_nxt;
      level_r <= level_nxt;
    end
  end

  assign stat.busy      = busy_r;
  assign stat.level_nxt = level_nxt;

endmodule

// ===== hw/rtl/fbsl_rx.sv =====
// Receiver: run counters, receive shift register and the hunt/collect/ready sequencer.
// Depends on fbsl_pkg for the phase type and the control and status structs.
module fbsl_rx (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [3:0]          run_length,
  input  logic [7:0]          sync_pattern,
  input  fbsl_pkg::rx_ctrl_t  ctrl,
  output fbsl_pkg::rx_stat_t  stat
);

  fbsl_pkg::rx_phase_t phase_r, phase_nxt;
  logic [7:0] shift_r, shift_nxt;
  logic [3:0] high_r, high_nxt, high_b;
  logic [3:0] low_r, low_nxt, low_b;
  logic [2:0] cnt_r, cnt_nxt;
  logic       got_hi, got_lo;

  always_comb begin
    high_b = ctrl.level ? ((high_r == fbsl_pkg::RUN_MAX) ? high_r : high_r + 4'd1) : 4'd0;
    low_b  = ctrl.level ? 4'd0 : ((low_r == fbsl_pkg::RUN_MAX) ? low_r : low_r + 4'd1);
    got_hi = high_b >= run_length;
    got_lo = !got_hi && (low_b >= run_length);
  end

  always_comb begin
    phase_nxt = phase_r;
    shift_nxt = shift_r;
    high_nxt  = high_r;
    low_nxt   = low_r;
    cnt_nxt   = cnt_r;
    if (ctrl.sample && phase_r != fbsl_pkg::PH_READY) begin
      high_nxt = got_hi ? 4'd0 : high_b;
      low_nxt  = got_lo ? 4'd0 : low_b;
      if (got_hi || got_lo) begin
        shift_nxt = {shift_r[6:0], got_hi};
        if (phase_r == fbsl_pkg::PH_HUNT) begin
          if (shift_nxt == sync_pattern) begin
            phase_nxt = fbsl_pkg::PH_COLLECT;
            cnt_nxt   = '0;
          end
        end else begin
          cnt_nxt = cnt_r + 3'd1;
          if (cnt_r == fbsl_pkg::LAST_BIT) begin
            phase_nxt = fbsl_pkg::PH_READY;
          end
        end
      end
    end else if (ctrl.read && phase_r == fbsl_pkg::PH_READY) begin
      phase_nxt = fbsl_pkg::PH_HUNT;
      cnt_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= fbsl_pkg::PH_HUNT;
      shift_r <= '0;
      high_r  <= '0;
      low_r   <= '0;
      cnt_r   <= '0;
    end else begin
      phase_r <= phase_nxt;
      shift_r <= shift_nxt;
      high_r  <= high_nxt;
      low_r   <= low_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

  assign stat.ready = (phase_r == fbsl_pkg::PH_READY);
  assign stat.shift = shift_r;

endmodule

// ===== hw/rtl/framed_bit_serial_link_core.sv =====
// Framed bit-serial link core: input decode, configuration registers, result register.
// Depends on fbsl_pkg, the channel interfaces in fbsl_if, fbsl_tx and fbsl_rx.
//
// Every input transfer carries one command: send request, transmit tick,
// receive sample or read. Each produces exactly one result transfer with
// status, the transmit line level after the command, and the received byte.
// The command is applied to the transmitter or receiver state in the cycle
// it is accepted and its result is captured in the output register, so the
// result appears in the cycle after the input transfer. One command is taken
// every cycle; the only limit is the single result register.
// The input is ready while the result register is empty or its result is
// taken in the same cycle. A stalled receiver therefore stalls the input
// after one pending result, and nothing is lost.
// Configuration writes on cfg_we take effect on the next command; a frame
// already loaded keeps its patterns. Index 3 is ignored.
// Synchronous reset clears the transmitter control state and the receiver (hunting
// for sync), empties the result register and restores the register defaults.
module framed_bit_serial_link_core (
  input  logic        clk,
  input  logic        rst_n,
  fbsl_in_if.sink     in_ch,
  fbsl_out_if.source  out_ch,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  logic [3:0] run_length_r;
  logic [7:0] sync_pattern_r;
  logic [7:0] end_pattern_r;

  logic       out_valid_r;
  logic       status_r, status_nxt;
  logic       tx_line_r;
  logic [7:0] rx_byte_r, rx_byte_nxt;
  logic       in_fire;

  fbsl_pkg::tx_ctrl_t tx_ctrl;
  fbsl_pkg::tx_stat_t tx_stat;
  fbsl_pkg::rx_ctrl_t rx_ctrl;
  fbsl_pkg::rx_stat_t rx_stat;

  assign in_ch.ready = !out_valid_r || out_ch.ready;
  assign in_fire     = in_ch.valid && in_ch.ready;

  always_comb begin
    tx_ctrl.load      = in_fire && (in_ch.kind == fbsl_pkg::KIND_SEND);
    tx_ctrl.tick      = in_fire && (in_ch.kind == fbsl_pkg::KIND_TICK);
    tx_ctrl.data_byte = in_ch.data_byte;
    rx_ctrl.sample    = in_fire && (in_ch.kind == fbsl_pkg::KIND_SAMPLE);
    rx_ctrl.level     = in_ch.line_level;
    rx_ctrl.read      = in_fire && (in_ch.kind == fbsl_pkg::KIND_READ);
  end

  always_comb begin
    status_nxt  = 1'b0;
    rx_byte_nxt = '0;
    unique case (in_ch.kind)
      fbsl_pkg::KIND_SEND: begin
        status_nxt = tx_stat.busy;
      end
      fbsl_pkg::KIND_READ: begin
        status_nxt  = !rx_stat.ready;
        rx_byte_nxt = rx_stat.ready ? rx_stat.shift : 8'd0;
      end
      default: begin
        status_nxt = 1'b0;
      end
    endcase
  end

  fbsl_tx u_tx (
    .clk          (clk),
    .rst_n        (rst_n),
    .sync_pattern (sync_pattern_r),
    .end_pattern  (end_pattern_r),
    .ctrl         (tx_ctrl),
    .stat         (tx_stat)
  );

  fbsl_rx u_rx (
    .clk          (clk),
    .rst_n        (rst_n),
    .run_length   (run_length_r),
    .sync_pattern (sync_pattern_r),
    .ctrl         (rx_ctrl),
    .stat         (rx_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_length_r   <= fbsl_pkg::RUN_RESET;
      sync_pattern_r <= fbsl_pkg::SYNC_RESET;
      end_pattern_r  <= fbsl_pkg::END_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        fbsl_pkg::CFG_RUN_LENGTH:   run_length_r   <= cfg_wdata[3:0];
        fbsl_pkg::CFG_SYNC_PATTERN: sync_pattern_r <= cfg_wdata;
        fbsl_pkg::CFG_END_PATTERN:  end_pattern_r  <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_fire) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
    if (in_fire) begin
      status_r  <= status_nxt;
      tx_line_r <= tx_stat.level_nxt;
      rx_byte_r <= rx_byte_nxt;
    end
  end

  assign out_ch.valid   = out_valid_r;
  assign out_ch.status  = status_r;
  assign out_ch.tx_line = tx_line_r;
  assign out_ch.rx_byte = rx_byte_r;

  a_send_sets_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (tx_ctrl.load && !tx_stat.busy) |=> tx_stat.busy)
    else $error("accepted send did not start the transmitter");

  a_tick_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (tx_ctrl.tick || rx_ctrl.sample) |=> !out_ch.status)
    else $error("tick or sample result carries a nonzero status");

  a_byte_needs_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && rx_byte_r != 8'd0) |-> !status_r)
    else $error("received byte returned with status set");

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (out_valid_r && !out_ch.ready))
    else $error("input stalled while the result register can accept");

endmodule

// ===== tb/framed_bit_serial_link_core_tb.sv =====
// Self-checking testbench for framed_bit_serial_link_core: line commands, frame
// reception and transmission checked against a cycle-free model of the link.
// Depends on fbsl_pkg, the channel interfaces in fbsl_if and the core itself.
module framed_bit_serial_link_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] CFG_UNUSED = 2'd3;
  localparam int LONG_HOLD = 150;
  localparam int STALL_LIMIT = 2000;
  localparam int MAX_REPORTS = 10;

  typedef struct {
    fbsl_pkg::kind_t kind;
    logic [7:0] data_byte;
    logic line_level;
  } link_cmd_t;

  typedef struct {
    logic status;
    logic tx_line;
    logic [7:0] rx_byte;
  } link_reply_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = fbsl_pkg::CFG_RUN_LENGTH;
  logic [7:0] cfg_wdata = 8'h00;

  fbsl_in_if in_ch ();
  fbsl_out_if out_ch ();

  framed_bit_serial_link_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  // Link model state.
  logic [3:0] run_len = fbsl_pkg::RUN_RESET;
  logic [7:0] sync_pat = fbsl_pkg::SYNC_RESET;
  logic [7:0] end_pat = fbsl_pkg::END_RESET;
  logic [7:0] tx_frame [3] = '{8'h00, 8'h00, 8'h00};
  logic [2:0] tx_bit_cnt = 3'd0;
  logic [1:0] tx_byte_idx = 2'd0;
  logic tx_busy = 1'b0;
  logic tx_level = 1'b0;
  fbsl_pkg::rx_phase_t rx_ph = fbsl_pkg::PH_HUNT;
  logic [7:0] rx_shift = 8'h00;
  logic [3:0] high_run = 4'd0;
  logic [3:0] low_run = 4'd0;
  logic [2:0] rx_bit_cnt = 3'd0;

  link_cmd_t link_cmds [$];
  link_reply_t expected_replies [$];

  bit offered = 1'b0;
  bit calm = 1'b0;
  bit long_hold_done = 1'b0;
  int in_gap = 0;
  int out_gap = 0;
  int replies_checked = 0;
  int fail_count = 0;
  int idle_cycles = 0;
  int phase_cmds = 0;

  initial begin
    forever #5 clk = ~clk;
  end

  function automatic void tick_model();
    logic [1:0] idx;
    if (!tx_busy) return;
    idx = (tx_byte_idx <= fbsl_pkg::LAST_BYTE) ? tx_byte_idx : 2'd0;
    tx_level = tx_frame[idx][7];
    tx_frame[idx] = tx_frame[idx] << 1;
    if (tx_bit_cnt == fbsl_pkg::LAST_BIT) begin
      tx_bit_cnt = 3'd0;
      if (idx == fbsl_pkg::LAST_BYTE) begin
        tx_byte_idx = 2'd0;
        tx_busy = 1'b0;
      end else begin
        tx_byte_idx = idx + 2'd1;
      end
    end else begin
      tx_bit_cnt = tx_bit_cnt + 3'd1;
    end
  endfunction

  function automatic void sample_model(logic lvl);
    logic got;
    logic rx_bit;
    got = 1'b0;
    rx_bit = 1'b0;
    if (rx_ph == fbsl_pkg::PH_READY) return;
    if (lvl) begin
      high_run = (high_run == fbsl_pkg::RUN_MAX) ? fbsl_pkg::RUN_MAX : high_run + 4'd1;
      low_run = 4'd0;
    end else begin
      low_run = (low_run == fbsl_pkg::RUN_MAX) ? fbsl_pkg::RUN_MAX : low_run + 4'd1;
      high_run = 4'd0;
    end
    if (high_run >= run_len) begin
      high_run = 4'd0;
      got = 1'b1;
      rx_bit = 1'b1;
    end else if (low_run >= run_len) begin
      low_run = 4'd0;
      got = 1'b1;
    end
    if (!got) return;
    rx_shift = {rx_shift[6:0], rx_bit};
    if (rx_ph == fbsl_pkg::PH_HUNT) begin
      if (rx_shift == sync_pat) begin
        rx_ph = fbsl_pkg::PH_COLLECT;
        rx_bit_cnt = 3'd0;
      end
    end else if (rx_bit_cnt == fbsl_pkg::LAST_BIT) begin
      rx_bit_cnt = 3'd0;
      rx_ph = fbsl_pkg::PH_READY;
    end else begin
      rx_bit_cnt = rx_bit_cnt + 3'd1;
    end
  endfunction

  function automatic link_reply_t predict_reply(link_cmd_t c);
    link_reply_t r;
    r.status = 1'b0;
    r.rx_byte = 8'h00;
    case (c.kind)
      fbsl_pkg::KIND_SEND: begin
        if (tx_busy) begin
          r.status = 1'b1;
        end else begin
          tx_frame[0] = sync_pat;
          tx_frame[1] = c.data_byte;
          tx_frame[2] = end_pat;
          tx_bit_cnt = 3'd0;
          tx_byte_idx = 2'd0;
          tx_busy = 1'b1;
        end
      end
      fbsl_pkg::KIND_TICK: tick_model();
      fbsl_pkg::KIND_SAMPLE: sample_model(c.line_level);
      default: begin
        if (rx_ph == fbsl_pkg::PH_READY) begin
          r.rx_byte = rx_shift;
          rx_ph = fbsl_pkg::PH_HUNT;
          rx_bit_cnt = 3'd0;
        end else begin
          r.status = 1'b1;
        end
      end
    endcase
    r.tx_line = tx_level;
    return r;
  endfunction

  function automatic void push_cmd(fbsl_pkg::kind_t k, logic [7:0] d, logic lvl);
    link_cmd_t c;
    c.kind = k;
    c.data_byte = d;
    c.line_level = lvl;
    link_cmds.push_back(c);
    phase_cmds++;
  endfunction

  function automatic void push_bit(logic lvl, int span, bit glitch);
    if (glitch) push_cmd(fbsl_pkg::KIND_SAMPLE, 8'($urandom), ~lvl);
    for (int k = 0; k < span; k++) push_cmd(fbsl_pkg::KIND_SAMPLE, 8'($urandom), lvl);
  endfunction

  function automatic void push_rx_frame();
    logic [15:0] bits;
    int span;
    int lead;
    span = (run_len == 4'd0) ? 1 : int'(run_len);
    lead = $urandom_range(0, 2);
    bits = {sync_pat, 8'($urandom)};
    if ($urandom_range(0, 1) == 0) push_cmd(fbsl_pkg::KIND_READ, 8'($urandom), 1'($urandom));
    for (int i = 0; i < lead; i++) push_bit(1'($urandom), span, 1'b0);
    for (int i = 15; i >= 0; i--) push_bit(bits[i], span, $urandom_range(0, 15) == 0);
    if ($urandom_range(0, 3) != 0) push_cmd(fbsl_pkg::KIND_READ, 8'($urandom), 1'($urandom));
  endfunction

  function automatic void push_tx_frame();
    int n;
    int busy_at;
    n = 24 + $urandom_range(0, 2);
    busy_at = $urandom_range(0, 36);
    push_cmd(fbsl_pkg::KIND_SEND, 8'($urandom), 1'($urandom));
    for (int i = 0; i < n; i++) begin
      if (i == busy_at) push_cmd(fbsl_pkg::KIND_SEND, 8'($urandom), 1'($urandom));
      push_cmd(fbsl_pkg::KIND_TICK, 8'($urandom), 1'($urandom));
    end
  endfunction

  function automatic void push_noise();
    int n;
    n = $urandom_range(5, 20);
    for (int i = 0; i < n; i++) begin
      push_cmd(fbsl_pkg::kind_t'($urandom_range(0, 3)), 8'($urandom), 1'($urandom));
    end
  endfunction

  task automatic wait_drained();
    while (link_cmds.size() != 0 || offered || expected_replies.size() != 0) begin
      @(posedge clk);
    end
    @(negedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [7:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      fbsl_pkg::CFG_RUN_LENGTH: run_len = val[3:0];
      fbsl_pkg::CFG_SYNC_PATTERN: sync_pat = val;
      fbsl_pkg::CFG_END_PATTERN: end_pat = val;
      default: ;
    endcase
  endtask

  task automatic run_phase(logic [3:0] run, logic [7:0] sync, logic [7:0] fin, int n);
    int pick;
    wait_drained();
    write_reg(fbsl_pkg::CFG_RUN_LENGTH, {4'd0, run});
    write_reg(fbsl_pkg::CFG_SYNC_PATTERN, sync);
    write_reg(fbsl_pkg::CFG_END_PATTERN, fin);
    phase_cmds = 0;
    while (phase_cmds < n) begin
      pick = $urandom_range(0, 9);
      if (pick < 5) push_rx_frame();
      else if (pick < 8) push_tx_frame();
      else push_noise();
    end
  endtask

  // Input side: one item is offered at a time and held until its transfer.
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (offered) begin
      in_ch.valid <= 1'b1;
    end else if (in_gap > 0) begin
      in_ch.valid <= 1'b0;
      in_gap--;
    end else if (link_cmds.size() != 0 && !calm && $urandom_range(0, 19) == 0) begin
      in_ch.valid <= 1'b0;
      in_gap = $urandom_range(0, 7);
    end else if (link_cmds.size() != 0) begin
      in_ch.valid <= 1'b1;
      in_ch.kind <= link_cmds[0].kind;
      in_ch.data_byte <= link_cmds[0].data_byte;
      in_ch.line_level <= link_cmds[0].line_level;
      offered = 1'b1;
    end else begin
      in_ch.valid <= 1'b0;
    end
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (out_gap > 0) begin
      out_ch.ready <= 1'b0;
      out_gap--;
    end else if (!long_hold_done && replies_checked >= 400 && link_cmds.size() > 20) begin
      out_ch.ready <= 1'b0;
      long_hold_done = 1'b1;
      out_gap = LONG_HOLD - 1;
    end else if (!calm && $urandom_range(0, 11) == 0) begin
      out_ch.ready <= 1'b0;
      out_gap = $urandom_range(0, 7);
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    link_reply_t exp_r;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        replies_checked++;
        if (expected_replies.size() == 0) begin
          if (fail_count < MAX_REPORTS) begin
            $display("unexpected reply: status=%0b tx_line=%0b rx_byte=%02h",
                     out_ch.status, out_ch.tx_line, out_ch.rx_byte);
          end
          fail_count++;
        end else begin
          exp_r = expected_replies.pop_front();
          if (out_ch.status !== exp_r.status || out_ch.tx_line !== exp_r.tx_line ||
              out_ch.rx_byte !== exp_r.rx_byte) begin
            if (fail_count < MAX_REPORTS) begin
              $display("reply %0d mismatch: expected status=%0b tx_line=%0b rx_byte=%02h",
                       replies_checked, exp_r.status, exp_r.tx_line, exp_r.rx_byte);
              $display("  actual status=%0b tx_line=%0b rx_byte=%02h",
                       out_ch.status, out_ch.tx_line, out_ch.rx_byte);
            end
            fail_count++;
          end
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        offered = 1'b0;
        expected_replies.push_back(predict_reply(link_cmds.pop_front()));
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= STALL_LIMIT) begin
        $display("framed_bit_serial_link_core_tb NOT OK");
        $finish;
      end
    end
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.kind = fbsl_pkg::KIND_SEND;
    in_ch.data_byte = 8'h00;
    in_ch.line_level = 1'b0;
    out_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset defaults: a read with nothing ready, a tick while idle, short runs.
    push_cmd(fbsl_pkg::KIND_READ, 8'h00, 1'b0);
    push_cmd(fbsl_pkg::KIND_TICK, 8'hFF, 1'b1);
    push_cmd(fbsl_pkg::KIND_SAMPLE, 8'h00, 1'b1);
    push_cmd(fbsl_pkg::KIND_SAMPLE, 8'hFF, 1'b0);
    wait_drained();

    // A zero run length turns every sample into a one bit, whatever its level.
    write_reg(fbsl_pkg::CFG_RUN_LENGTH, 8'h00);
    write_reg(fbsl_pkg::CFG_SYNC_PATTERN, 8'h00);
    write_reg(fbsl_pkg::CFG_END_PATTERN, 8'hFF);
    write_reg(CFG_UNUSED, 8'h5A);
    push_cmd(fbsl_pkg::KIND_SAMPLE, 8'h00, 1'b0);
    for (int i = 7; i >= 0; i--) push_cmd(fbsl_pkg::KIND_SAMPLE, 8'h00, 1'(8'hA5 >> i));
    push_cmd(fbsl_pkg::KIND_SAMPLE, 8'h00, 1'b1);
    push_cmd(fbsl_pkg::KIND_READ, 8'h00, 1'b0);
    push_cmd(fbsl_pkg::KIND_READ, 8'h00, 1'b0);
    push_cmd(fbsl_pkg::KIND_SEND, 8'hFF, 1'b0);
    push_cmd(fbsl_pkg::KIND_SEND, 8'h00, 1'b0);
    repeat (3) push_cmd(fbsl_pkg::KIND_TICK, 8'h00, 1'b0);

    // The frame loaded above finishes in the next phase with the patterns it was loaded with.
    run_phase(4'd1, 8'($urandom), 8'($urandom), 350);
    run_phase(4'd2, 8'($urandom), 8'($urandom), 300);
    run_phase(fbsl_pkg::RUN_RESET, fbsl_pkg::SYNC_RESET, fbsl_pkg::END_RESET, 350);
    run_phase(fbsl_pkg::RUN_MAX, 8'hFF, 8'h00, 300);
    run_phase(4'd3, 8'h00, 8'hFF, 300);
    wait_drained();
    calm = 1'b1;
    run_phase(4'd1, 8'($urandom), 8'($urandom), 250);
    wait_drained();
    repeat (4) @(posedge clk);

    if (fail_count == 0 && expected_replies.size() == 0) begin
      $display("framed_bit_serial_link_core_tb OK");
    end else begin
      $display("framed_bit_serial_link_core_tb NOT OK");
    end
    $finish;
  end

endmodule
